@@ design/bdpc_pkg.sv @@
// types and constants for the button debounce and press classifier
// used by every module of the block; depends on nothing
`default_nettype none
package bdpc_pkg;

	typedef enum logic [1:0] {
		FUNC_TICK = 2'd0,
		FUNC_EDGE = 2'd1,
		FUNC_READ = 2'd2
	} func_t;

	localparam logic [1:0] EV_NONE  = 2'd0;
	localparam logic [1:0] EV_CLICK = 2'd1;
	localparam logic [1:0] EV_LONG  = 2'd2;

	localparam logic REG_LONG_PRESS = 1'b0;
	localparam logic REG_STABLE     = 1'b1;

	localparam int          PIN_W       = 3;
	localparam int          MASK_W      = 3;
	localparam logic [15:0] LONG_RESET  = 16'd100;
	localparam logic [3:0]  STABLE_RESET = 4'd3;
	localparam logic [3:0]  MATCH_MAX   = 4'hF;
	localparam logic [15:0] HOLD_MAX    = 16'hFFFF;

	typedef struct packed {
		logic tick;
		logic arm;
		logic rd;
		logic pin;
	} lane_ctl_t;

	typedef struct packed {
		logic pressed_nxt;
		logic long_pend;
		logic click_pend;
	} lane_stat_t;

endpackage
`default_nettype wire

@@ design/bdpc_lane.sv @@
// one button lane: debounce counter, hold timer and pending click/long flags
// depends on bdpc_pkg
`default_nettype none
module bdpc_lane (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire [15:0]             long_press_ticks,
	input  wire [3:0]              stable_count,
	input  bdpc_pkg::lane_ctl_t    ctl,
	output bdpc_pkg::lane_stat_t   stat
);
	import bdpc_pkg::*;

	logic        sampled_q, sampled_d;
	logic        stable_q, stable_d;
	logic [3:0]  match_q, match_d, match_inc;
	logic        armed_q, armed_d;
	logic [15:0] hold_q, hold_d;
	logic        click_q, click_d;
	logic        long_q, long_d;

	always_comb begin
		sampled_d = sampled_q;
		stable_d  = stable_q;
		match_d   = match_q;
		armed_d   = armed_q;
		hold_d    = hold_q;
		click_d   = click_q;
		long_d    = long_q;
		match_inc = (match_q == MATCH_MAX) ? match_q : match_q + 4'd1;
		if (ctl.tick) begin
			if (!armed_q) begin
				if (!stable_q) begin
					hold_d = (hold_q == HOLD_MAX) ? hold_q : hold_q + 16'd1;
					if (hold_d >= long_press_ticks)
						long_d = 1'b1;
				end
			end else if (ctl.pin != sampled_q) begin
				sampled_d = ctl.pin;
				match_d   = 4'd0;
			end else if (match_inc >= stable_count) begin
				match_d = 4'd0;
				armed_d = 1'b0;
				if (sampled_q != stable_q) begin
					stable_d = sampled_q;
					if (sampled_q && !stable_q && (hold_q < long_press_ticks))
						click_d = 1'b1;
					hold_d = 16'd0;
				end
			end else begin
				match_d = match_inc;
			end
		end else if (ctl.arm) begin
			armed_d = 1'b1;
		end else if (ctl.rd) begin
			if (long_q)
				long_d = 1'b0;
			else if (click_q)
				click_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sampled_q <= 1'b1;
			stable_q  <= 1'b1;
			match_q   <= 4'd0;
			armed_q   <= 1'b0;
			hold_q    <= 16'd0;
			click_q   <= 1'b0;
			long_q    <= 1'b0;
		end else begin
			sampled_q <= sampled_d;
			stable_q  <= stable_d;
			match_q   <= match_d;
			armed_q   <= armed_d;
			hold_q    <= hold_d;
			click_q   <= click_d;
			long_q    <= long_d;
		end
	end

	assign stat.pressed_nxt = ~stable_d;
	assign stat.long_pend   = long_q;
	assign stat.click_pend  = click_q;

endmodule
`default_nettype wire

@@ design/bdpc_merge.sv @@
// merging stage: builds the pressed mask and picks the read event of one lane
// depends on bdpc_pkg
`default_nettype none
module bdpc_merge #(
	parameter int NUM_BUTTONS = 3
) (
	input  bdpc_pkg::lane_stat_t   stat [NUM_BUTTONS],
	input  wire                    is_read,
	input  wire [1:0]              button,
	output logic [1:0]             event_res,
	output logic [2:0]             pressed_mask
);
	import bdpc_pkg::*;

	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < NUM_BUTTONS) begin : g_on
			assign pressed_mask[g] = stat[g].pressed_nxt;
		end else begin : g_off
			assign pressed_mask[g] = 1'b0;
		end
	end

	always_comb begin
		event_res = EV_NONE;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (is_read && (32'(button) == i)) begin
				if (stat[i].long_pend)
					event_res = EV_LONG;
				else if (stat[i].click_pend)
					event_res = EV_CLICK;
			end
		end
	end

endmodule
`default_nettype wire

@@ design/button_debounce_press_classifier.sv @@
// button debounce and press classifier, top level
// depends on bdpc_pkg, bdpc_lane and bdpc_merge
//
// usage:
//   input channel (in_valid/in_ready) carries func, button and pin_levels.
//   func tick samples all pins, edge arms one button, read returns and
//   clears one button's pending flag (long press before click).
//   output channel (out_valid/out_ready) gives one beat per input beat:
//   event_res and pressed_mask taken after the item is applied.
//   the result is registered into the output register or skid entry.
//   throughput: one item per cycle while in_ready is high; all lanes
//   update in parallel on acceptance, a two-entry output stage holds
//   finished results. when the receiver stalls, one more item is taken
//   into the skid entry, then in_ready drops until the output drains.
//   config: cfg_we writes cfg_data into register cfg_index at once
//   (0 long_press_ticks, 1 stable_count); the user writes only while the
//   block is idle, which it does not enforce. reset: all buttons released
//   and disarmed, flags clear, registers at 100 and 3, output empty.
`default_nettype none
module button_debounce_press_classifier #(
	parameter int NUM_BUTTONS = 3
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        in_valid,
	output logic       in_ready,
	input  wire [1:0]  func,
	input  wire [1:0]  button,
	input  wire [2:0]  pin_levels,
	output logic       out_valid,
	input  wire        out_ready,
	output logic [1:0] event_res,
	output logic [2:0] pressed_mask,
	input  wire        cfg_we,
	input  wire        cfg_index,
	input  wire [15:0] cfg_data
);
	import bdpc_pkg::*;

	logic [15:0] long_press_q;
	logic [3:0]  stable_cnt_q;
	logic        accept, pop;
	logic        is_tick, is_edge, is_read;
	logic [1:0]  ev_nxt;
	logic [2:0]  mask_nxt;
	logic        out_valid_q, skid_valid_q;
	logic [1:0]  out_ev_q, skid_ev_q;
	logic [2:0]  out_mask_q, skid_mask_q;
	lane_stat_t  stat [NUM_BUTTONS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q <= LONG_RESET;
			stable_cnt_q <= STABLE_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LONG_PRESS: long_press_q <= cfg_data;
				REG_STABLE:     stable_cnt_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign in_ready = ~skid_valid_q;
	assign accept   = in_valid & in_ready;
	assign pop      = out_valid_q & out_ready;

	always_comb begin
		is_tick = 1'b0;
		is_edge = 1'b0;
		is_read = 1'b0;
		case (func)
			FUNC_TICK: is_tick = accept;
			FUNC_EDGE: is_edge = accept;
			FUNC_READ: is_read = accept;
			default: ;
		endcase
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		lane_ctl_t ctl;
		assign ctl.tick = is_tick;
		assign ctl.arm  = is_edge && (32'(button) == g);
		assign ctl.rd   = is_read && (32'(button) == g);
		if (g < PIN_W) begin : g_pin
			assign ctl.pin = pin_levels[g];
		end else begin : g_nopin
			assign ctl.pin = 1'b0;
		end
		bdpc_lane u_lane (
			.clk              (clk),
			.arst_n           (arst_n),
			.long_press_ticks (long_press_q),
			.stable_count     (stable_cnt_q),
			.ctl              (ctl),
			.stat             (stat[g])
		);
	end

	bdpc_merge #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_merge (
		.stat         (stat),
		.is_read      (is_read),
		.button       (button),
		.event_res    (ev_nxt),
		.pressed_mask (mask_nxt)
	);

	// output register plus skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop)
				skid_valid_q <= 1'b0;
		end else if (accept) begin
			if (!out_valid_q || pop)
				out_valid_q <= 1'b1;
			else
				skid_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_ev_q   <= skid_ev_q;
				out_mask_q <= skid_mask_q;
			end
		end else if (accept) begin
			if (!out_valid_q || pop) begin
				out_ev_q   <= ev_nxt;
				out_mask_q <= mask_nxt;
			end else begin
				skid_ev_q   <= ev_nxt;
				skid_mask_q <= mask_nxt;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = out_ev_q;
	assign pressed_mask = out_mask_q;

	// skid entry is only ever filled behind a waiting output beat
	a_skid_behind_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry valid with empty output register");

	// draining the output with a skid beat waiting keeps output valid
	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && out_ready) |=> (out_valid_q && !skid_valid_q))
		else $error("skid beat lost on drain");

	// an accepted beat into an empty output shows up next cycle
	a_accept_shows: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !out_valid_q) |=> (out_valid_q && !skid_valid_q))
		else $error("accepted beat not presented");

endmodule
`default_nettype wire
